// ----- rtl/dsa_sg_pkg.sv -----
// Shared types and constants for the DSA signature generator.
// Operation codes, register indexes, reset values and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package dsa_sg_pkg;

  // Width of the message, nonce and result fields
  localparam int FIELD_W = 16;
  // Width of the configuration register index
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_BASE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_KEY = 8'd3;

  // Reset values of the configuration registers
  localparam int PRIME_P_RST     = 23;
  localparam int PRIME_Q_RST     = 11;
  localparam int GEN_BASE_RST    = 2;
  localparam int PRIVATE_KEY_RST = 1;

  // Datapath operations issued by the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_DIV_EX   = 5'd2;
  localparam logic [OP_W-1:0] OP_CAP_EX   = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV_HP   = 5'd4;
  localparam logic [OP_W-1:0] OP_CAP_HP   = 5'd5;
  localparam logic [OP_W-1:0] OP_POW_MUL  = 5'd6;
  localparam logic [OP_W-1:0] OP_CAP_POW  = 5'd7;
  localparam logic [OP_W-1:0] OP_CAP_G    = 5'd8;
  localparam logic [OP_W-1:0] OP_CAP_Y    = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV_R    = 5'd10;
  localparam logic [OP_W-1:0] OP_CAP_R    = 5'd11;
  localparam logic [OP_W-1:0] OP_SET_FAIL = 5'd12;
  localparam logic [OP_W-1:0] OP_DIV_KQ   = 5'd13;
  localparam logic [OP_W-1:0] OP_CAP_KQ   = 5'd14;
  localparam logic [OP_W-1:0] OP_DIV_EUC  = 5'd15;
  localparam logic [OP_W-1:0] OP_MUL_EUC  = 5'd16;
  localparam logic [OP_W-1:0] OP_CAP_EUC  = 5'd17;
  localparam logic [OP_W-1:0] OP_DIV_HQ   = 5'd18;
  localparam logic [OP_W-1:0] OP_CAP_HQ   = 5'd19;
  localparam logic [OP_W-1:0] OP_MUL_XR   = 5'd20;
  localparam logic [OP_W-1:0] OP_CAP_SUM  = 5'd21;
  localparam logic [OP_W-1:0] OP_MUL_S    = 5'd22;
  localparam logic [OP_W-1:0] OP_CAP_S    = 5'd23;
  localparam logic [OP_W-1:0] OP_PUBLISH  = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic e_zero;
    logic q_le1;
    logic r1_zero;
    logic r0_one;
  } stat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sig_r;
    logic [FIELD_W-1:0] sig_s;
    logic [FIELD_W-1:0] pub_key;
    logic [FIELD_W-1:0] generator;
    logic               status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/dsa_sg_if.sv -----
// Channel interfaces of the DSA signature generator: request, response and
// configuration write. Depends on dsa_sg_pkg.
`default_nettype none

interface dsa_sg_req_if;
  logic                            valid;
  logic                            ready;
  logic [dsa_sg_pkg::FIELD_W-1:0]  msg_hash;
  logic [dsa_sg_pkg::FIELD_W-1:0]  nonce;
  modport source (output valid, msg_hash, nonce, input ready);
  modport sink   (input valid, msg_hash, nonce, output ready);
endinterface

interface dsa_sg_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [dsa_sg_pkg::FIELD_W-1:0]  sig_r;
  logic [dsa_sg_pkg::FIELD_W-1:0]  sig_s;
  logic [dsa_sg_pkg::FIELD_W-1:0]  pub_key;
  logic [dsa_sg_pkg::FIELD_W-1:0]  generator;
  logic                            status;
  modport source (output valid, sig_r, sig_s, pub_key, generator, status, input ready);
  modport sink   (input valid, sig_r, sig_s, pub_key, generator, status, output ready);
endinterface

interface dsa_sg_cfg_if #(
  parameter int DATA_W = 16
);
  logic                              valid;
  logic                              ready;
  logic [dsa_sg_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]                 data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dsa_signature_generate.sv -----
// Top level of the DSA signature generator: channel ports, controller and
// datapath. Uses dsa_sg_pkg, dsa_sg_if, dsa_sg_ctrl and dsa_sg_datapath.
//
//   Channel   Modport  Moves                                   Handshake
//   req_i     sink     msg_hash, nonce                         valid/ready
//   rsp_o     source   sig_r, sig_s, pub_key, generator, status valid/ready
//   cfg_i     sink     index, data (W = MOD_WIDTH bits)        valid/ready, ready always high
//
// One item at a time. The work is done by the bit-serial modular multipliers
// and the one-bit-a-cycle divider.
// Reset loads the register defaults (p 23, q 11, h 2, x 1); no clearing pass.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module dsa_signature_generate #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dsa_sg_req_if.sink  req_i,
  dsa_sg_rsp_if.source rsp_o,
  dsa_sg_cfg_if.sink  cfg_i
);

  dsa_sg_pkg::cmd_t  cmd;
  dsa_sg_pkg::stat_t stat;
  dsa_sg_pkg::res_t  res;
  logic              in_ready, out_valid;

  assign cfg_i.ready = 1'b1;

  dsa_sg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsa_sg_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (MOD_WIDTH'(cfg_i.data)),
    .msg_hash_i (req_i.msg_hash),
    .nonce_i    (req_i.nonce),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res)
  );

  assign req_i.ready     = in_ready;
  assign rsp_o.valid     = out_valid;
  assign rsp_o.sig_r     = res.sig_r;
  assign rsp_o.sig_s     = res.sig_s;
  assign rsp_o.pub_key   = res.pub_key;
  assign rsp_o.generator = res.generator;
  assign rsp_o.status    = res.status;

endmodule

`default_nettype wire

// ----- rtl/dsa_sg_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of two MOD_WIDTH-bit operands; no dependencies.
`default_nettype none

module dsa_sg_div #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MOD_WIDTH-1:0] num_i,
  input  wire logic [MOD_WIDTH-1:0] den_i,
  output logic                      done_o,
  output logic [MOD_WIDTH-1:0]      quot_o,
  output logic [MOD_WIDTH-1:0]      rem_o
);

  localparam int CntW = $clog2(MOD_WIDTH);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] quo_q, rem_q, den_q;
  logic [MOD_WIDTH:0]   rem_sh, rem_sub;
  logic                 ge;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    rem_sh  = {rem_q, quo_q[MOD_WIDTH-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MOD_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[MOD_WIDTH-2:0], ge};
      rem_q <= rem_sub[MOD_WIDTH-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/dsa_sg_modmul.sv -----
// Bit-serial modular multiplier, most significant multiplier bit first.
// Needs a < m; b may take any value. No dependencies.
`default_nettype none

module dsa_sg_modmul #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MOD_WIDTH-1:0] a_i,
  input  wire logic [MOD_WIDTH-1:0] b_i,
  input  wire logic [MOD_WIDTH-1:0] m_i,
  output logic                      done_o,
  output logic [MOD_WIDTH-1:0]      prod_o
);

  localparam int CntW = $clog2(MOD_WIDTH);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] acc_q, a_q, b_q, m_q;
  logic [MOD_WIDTH:0]   dbl, dbl_red, sum, sum_red;

  // acc = (2 acc + bit * a) mod m, kept below m
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? (dbl - {1'b0, m_q}) : dbl;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + (b_q[MOD_WIDTH-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= {1'b0, m_q}) ? (sum - {1'b0, m_q}) : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MOD_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= sum_red[MOD_WIDTH-1:0];
      b_q   <= {b_q[MOD_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/dsa_sg_datapath.sv -----
// Datapath: configuration registers, working registers, one divider and two
// modular multipliers, steered by controller operations. Uses dsa_sg_pkg,
// dsa_sg_div and dsa_sg_modmul.
`default_nettype none

module dsa_sg_datapath #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dsa_sg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [MOD_WIDTH-1:0]               cfg_data_i,
  input  wire logic [dsa_sg_pkg::FIELD_W-1:0]     msg_hash_i,
  input  wire logic [dsa_sg_pkg::FIELD_W-1:0]     nonce_i,
  input  wire dsa_sg_pkg::cmd_t                   cmd_i,
  output dsa_sg_pkg::stat_t                       stat_o,
  output dsa_sg_pkg::res_t                        res_o
);

  localparam int W      = MOD_WIDTH;
  localparam int FieldW = dsa_sg_pkg::FIELD_W;

  // Configuration
  logic [W-1:0] p_q, q_q, h_q, x_q;
  // Item and working registers
  logic [W-1:0] hash_q, k_q, e_q, acc_q, base_q, g_q, y_q, r_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q, tmp_q, s_q;
  logic         fail_q;
  dsa_sg_pkg::res_t res_q;

  logic         p_zero, q_zero;
  logic [W-1:0] one_p, pow_res, t_next;
  logic [W:0]   add_sum, add_red;

  logic         div_start, div_done;
  logic [W-1:0] div_num, div_den, div_quot, div_rem;
  logic         mul0_start, mul0_done, mul1_start, mul1_done;
  logic [W-1:0] mul0_a, mul0_b, mul0_m, mul0_prod, mul1_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= W'(dsa_sg_pkg::PRIME_P_RST);
      q_q <= W'(dsa_sg_pkg::PRIME_Q_RST);
      h_q <= W'(dsa_sg_pkg::GEN_BASE_RST);
      x_q <= W'(dsa_sg_pkg::PRIVATE_KEY_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsa_sg_pkg::REG_PRIME_P:     p_q <= cfg_data_i;
        dsa_sg_pkg::REG_PRIME_Q:     q_q <= cfg_data_i;
        dsa_sg_pkg::REG_GEN_BASE:    h_q <= cfg_data_i;
        dsa_sg_pkg::REG_PRIVATE_KEY: x_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    p_zero  = (p_q == '0);
    q_zero  = (q_q == '0);
    one_p   = (p_q == W'(1)) ? '0 : W'(1);
    pow_res = p_zero ? '0 : acc_q;
    // t0 - quo * t1 mod q
    t_next  = (t0_q >= mul0_prod) ? (t0_q - mul0_prod) : (t0_q + (q_q - mul0_prod));
    add_sum = {1'b0, tmp_q} + {1'b0, mul0_prod};
    add_red = (add_sum >= {1'b0, q_q}) ? (add_sum - {1'b0, q_q}) : add_sum;
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = q_q;
    case (cmd_i.op)
      dsa_sg_pkg::OP_DIV_EX:  div_num = p_q - W'(1);
      dsa_sg_pkg::OP_DIV_HP: begin
        div_num = h_q;
        div_den = p_q;
      end
      dsa_sg_pkg::OP_DIV_R:   div_num = pow_res;
      dsa_sg_pkg::OP_DIV_KQ:  div_num = k_q;
      dsa_sg_pkg::OP_DIV_EUC: begin
        div_num = r0_q;
        div_den = r1_q;
      end
      dsa_sg_pkg::OP_DIV_HQ:  div_num = hash_q;
      default:                div_start = 1'b0;
    endcase
  end

  // Multiplier operand selection; a is always reduced
  always_comb begin
    mul0_start = 1'b1;
    mul1_start = 1'b0;
    mul0_a     = base_q;
    mul0_b     = acc_q;
    mul0_m     = q_q;
    case (cmd_i.op)
      dsa_sg_pkg::OP_POW_MUL: begin
        mul0_m     = p_q;
        mul1_start = 1'b1;
      end
      dsa_sg_pkg::OP_MUL_EUC: begin
        mul0_a = t1_q;
        mul0_b = div_quot;
      end
      dsa_sg_pkg::OP_MUL_XR: begin
        mul0_a = r_q;
        mul0_b = x_q;
      end
      dsa_sg_pkg::OP_MUL_S: begin
        mul0_a = t0_q;
        mul0_b = tmp_q;
      end
      default: mul0_start = 1'b0;
    endcase
  end

  dsa_sg_div #(.MOD_WIDTH(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  dsa_sg_modmul #(.MOD_WIDTH(W)) u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul0_start),
    .a_i     (mul0_a),
    .b_i     (mul0_b),
    .m_i     (mul0_m),
    .done_o  (mul0_done),
    .prod_o  (mul0_prod)
  );

  // Squares the base alongside the accumulator product
  dsa_sg_modmul #(.MOD_WIDTH(W)) u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul1_start),
    .a_i     (base_q),
    .b_i     (base_q),
    .m_i     (p_q),
    .done_o  (mul1_done),
    .prod_o  (mul1_prod)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dsa_sg_pkg::OP_LOAD: begin
        hash_q <= W'(msg_hash_i);
        k_q    <= W'(nonce_i);
      end
      dsa_sg_pkg::OP_CAP_EX:  e_q <= q_zero ? '0 : div_quot;
      dsa_sg_pkg::OP_CAP_HP: begin
        base_q <= div_rem;
        acc_q  <= one_p;
      end
      dsa_sg_pkg::OP_CAP_POW: begin
        if (e_q[0]) begin
          acc_q <= mul0_prod;
        end
        base_q <= mul1_prod;
        e_q    <= e_q >> 1;
      end
      dsa_sg_pkg::OP_CAP_G: begin
        g_q    <= pow_res;
        base_q <= pow_res;
        e_q    <= x_q;
        acc_q  <= one_p;
      end
      dsa_sg_pkg::OP_CAP_Y: begin
        y_q    <= pow_res;
        base_q <= g_q;
        e_q    <= k_q;
        acc_q  <= one_p;
      end
      dsa_sg_pkg::OP_CAP_R:   r_q <= q_zero ? '0 : div_rem;
      dsa_sg_pkg::OP_SET_FAIL: begin
        s_q    <= '0;
        fail_q <= 1'b1;
      end
      dsa_sg_pkg::OP_CAP_KQ: begin
        r0_q <= q_q;
        r1_q <= div_rem;
        t0_q <= '0;
        t1_q <= W'(1);
      end
      dsa_sg_pkg::OP_CAP_EUC: begin
        r0_q <= r1_q;
        r1_q <= div_rem;
        t0_q <= t1_q;
        t1_q <= t_next;
      end
      dsa_sg_pkg::OP_CAP_HQ:  tmp_q <= div_rem;
      dsa_sg_pkg::OP_CAP_SUM: tmp_q <= add_red[W-1:0];
      dsa_sg_pkg::OP_CAP_S: begin
        s_q    <= mul0_prod;
        fail_q <= 1'b0;
      end
      dsa_sg_pkg::OP_PUBLISH: begin
        res_q.sig_r     <= FieldW'(r_q);
        res_q.sig_s     <= FieldW'(s_q);
        res_q.pub_key   <= FieldW'(y_q);
        res_q.generator <= FieldW'(g_q);
        res_q.status    <= fail_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.div_done = div_done;
    // Both multipliers run the same number of steps
    stat_o.mul_done = mul0_done | mul1_done;
    stat_o.e_zero   = (e_q == '0);
    stat_o.q_le1    = (q_q[W-1:1] == '0);
    stat_o.r1_zero  = (r1_q == '0);
    stat_o.r0_one   = (r0_q == W'(1));
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/dsa_sg_ctrl.sv -----
// Controller: sequences the exponent division, three exponentiations, the
// reduction of r, the inverse of the nonce and the s product. Uses dsa_sg_pkg.
`default_nettype none

module dsa_sg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire dsa_sg_pkg::stat_t stat_i,
  output dsa_sg_pkg::cmd_t       cmd_o
);

  localparam int StW = 5;
  localparam logic [StW-1:0] ST_IDLE    = 5'd0;
  localparam logic [StW-1:0] ST_EX      = 5'd1;
  localparam logic [StW-1:0] ST_EX_W    = 5'd2;
  localparam logic [StW-1:0] ST_HP      = 5'd3;
  localparam logic [StW-1:0] ST_HP_W    = 5'd4;
  localparam logic [StW-1:0] ST_POW     = 5'd5;
  localparam logic [StW-1:0] ST_POW_W   = 5'd6;
  localparam logic [StW-1:0] ST_R_W     = 5'd7;
  localparam logic [StW-1:0] ST_INV     = 5'd8;
  localparam logic [StW-1:0] ST_KQ_W    = 5'd9;
  localparam logic [StW-1:0] ST_EUC     = 5'd10;
  localparam logic [StW-1:0] ST_EUC_DW  = 5'd11;
  localparam logic [StW-1:0] ST_EUC_MW  = 5'd12;
  localparam logic [StW-1:0] ST_HQ_W    = 5'd13;
  localparam logic [StW-1:0] ST_XR      = 5'd14;
  localparam logic [StW-1:0] ST_XR_W    = 5'd15;
  localparam logic [StW-1:0] ST_S       = 5'd16;
  localparam logic [StW-1:0] ST_S_W     = 5'd17;
  localparam logic [StW-1:0] ST_OUT     = 5'd18;

  // Which exponentiation is running
  localparam logic [1:0] POW_G = 2'd0;
  localparam logic [1:0] POW_Y = 2'd1;
  localparam logic [1:0] POW_K = 2'd2;

  logic [StW-1:0] state_q, state_d;
  logic [1:0]     pow_q, pow_d;
  logic           out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    pow_d       = pow_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = dsa_sg_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = dsa_sg_pkg::OP_LOAD;
          state_d  = ST_EX;
        end
      end
      ST_EX: begin
        cmd_o.op = dsa_sg_pkg::OP_DIV_EX;
        state_d  = ST_EX_W;
      end
      ST_EX_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_EX;
          state_d  = ST_HP;
        end
      end
      ST_HP: begin
        cmd_o.op = dsa_sg_pkg::OP_DIV_HP;
        state_d  = ST_HP_W;
      end
      ST_HP_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_HP;
          pow_d    = POW_G;
          state_d  = ST_POW;
        end
      end
      ST_POW: begin
        if (stat_i.e_zero) begin
          case (pow_q)
            POW_G: begin
              cmd_o.op = dsa_sg_pkg::OP_CAP_G;
              pow_d    = POW_Y;
            end
            POW_Y: begin
              cmd_o.op = dsa_sg_pkg::OP_CAP_Y;
              pow_d    = POW_K;
            end
            default: begin
              cmd_o.op = dsa_sg_pkg::OP_DIV_R;
              state_d  = ST_R_W;
            end
          endcase
        end else begin
          cmd_o.op = dsa_sg_pkg::OP_POW_MUL;
          state_d  = ST_POW_W;
        end
      end
      ST_POW_W: begin
        if (stat_i.mul_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_POW;
          state_d  = ST_POW;
        end
      end
      ST_R_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_R;
          state_d  = ST_INV;
        end
      end
      ST_INV: begin
        if (stat_i.q_le1) begin
          cmd_o.op = dsa_sg_pkg::OP_SET_FAIL;
          state_d  = ST_OUT;
        end else begin
          cmd_o.op = dsa_sg_pkg::OP_DIV_KQ;
          state_d  = ST_KQ_W;
        end
      end
      ST_KQ_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_KQ;
          state_d  = ST_EUC;
        end
      end
      ST_EUC: begin
        if (stat_i.r1_zero) begin
          // Remainder chain ended: gcd must be one for an inverse
          if (stat_i.r0_one) begin
            cmd_o.op = dsa_sg_pkg::OP_DIV_HQ;
            state_d  = ST_HQ_W;
          end else begin
            cmd_o.op = dsa_sg_pkg::OP_SET_FAIL;
            state_d  = ST_OUT;
          end
        end else begin
          cmd_o.op = dsa_sg_pkg::OP_DIV_EUC;
          state_d  = ST_EUC_DW;
        end
      end
      ST_EUC_DW: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_MUL_EUC;
          state_d  = ST_EUC_MW;
        end
      end
      ST_EUC_MW: begin
        if (stat_i.mul_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_EUC;
          state_d  = ST_EUC;
        end
      end
      ST_HQ_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_HQ;
          state_d  = ST_XR;
        end
      end
      ST_XR: begin
        cmd_o.op = dsa_sg_pkg::OP_MUL_XR;
        state_d  = ST_XR_W;
      end
      ST_XR_W: begin
        if (stat_i.mul_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_SUM;
          state_d  = ST_S;
        end
      end
      ST_S: begin
        cmd_o.op = dsa_sg_pkg::OP_MUL_S;
        state_d  = ST_S_W;
      end
      ST_S_W: begin
        if (stat_i.mul_done) begin
          cmd_o.op = dsa_sg_pkg::OP_CAP_S;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = dsa_sg_pkg::OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pow_q       <= POW_G;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pow_q       <= pow_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/dsa_sg_checker.sv -----
// Port-level checks of the DSA signature generator, bound to the top level.
// Depends on dsa_signature_generate and dsa_sg_pkg.
`default_nettype none

module dsa_sg_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [dsa_sg_pkg::FIELD_W-1:0] sig_r_i,
  input wire logic [dsa_sg_pkg::FIELD_W-1:0] sig_s_i,
  input wire logic                           status_i
);

  logic in_acc, out_stall;

  assign in_acc    = in_valid_i & in_ready_i;
  assign out_stall = out_valid_i & ~out_ready_i;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A failed signature carries a zero s
  a_fail_s_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i) |-> (sig_s_i == '0))
    else $error("status set with non-zero sig_s");

  // One transaction at a time: no second accept straight after the first
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input taken while an item is in work");

  // A result cannot appear the cycle after its transaction is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result raised too early");

  // Stalled payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> ($stable(sig_r_i) && $stable(sig_s_i) && $stable(status_i)))
    else $error("result changed while stalled");

endmodule

bind dsa_signature_generate dsa_sg_checker u_dsa_sg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .sig_r_i     (rsp_o.sig_r),
  .sig_s_i     (rsp_o.sig_s),
  .status_i    (rsp_o.status)
);

`default_nettype wire
